[rtl/usbhid_pkg.sv]
// Shared types, request codes and descriptor tables of the USB HID control request handler.
`timescale 1ns / 1ps

package usbhid_pkg;

    localparam logic [7:0] REQ_GET_DESC = 8'h06;
    localparam logic [7:0] REQ_SET_ADDR = 8'h05;
    localparam logic [7:0] REQ_SET_CFG  = 8'h09;
    localparam logic [7:0] REQ_SET_IDLE = 8'h0A;

    localparam logic [7:0] BM_DEV_IN    = 8'h80;
    localparam logic [7:0] BM_IF_IN     = 8'h81;
    localparam logic [7:0] BM_STD_OUT   = 8'h00;
    localparam logic [7:0] BM_CLASS_OUT = 8'h21;

    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_REPORT = 8'h22;

    localparam int DEV_LEN = 18;
    localparam int CFG_LEN = 41;
    localparam int RPT_LEN = 45;

    localparam logic [15:0] VENDOR_RESET  = 16'h16C0;
    localparam logic [15:0] PRODUCT_RESET = 16'h05DC;

    localparam logic CFG_IDX_VENDOR  = 1'b0;
    localparam logic CFG_IDX_PRODUCT = 1'b1;

    typedef enum logic [2:0] {
        KIND_DATA  = 3'd0,
        KIND_EMPTY = 3'd1,
        KIND_ACK   = 3'd2,
        KIND_STALL = 3'd3,
        KIND_RESET = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        OP_DESC_DEV,
        OP_DESC_CFG,
        OP_DESC_RPT,
        OP_EMPTY,
        OP_SET_ADDR,
        OP_SET_CFG,
        OP_ACK,
        OP_STALL,
        OP_BUS_RESET
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] count;
        logic [6:0] addr;
    } cmd_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
        logic [6:0] addr;
        logic       addr_en;
        logic       cfg;
    } res_t;

    localparam logic [7:0] CFG_ROM [0:CFG_LEN-1] = '{
        8'h09, 8'h02, 8'h29, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h03, 8'h01, 8'h01, 8'h00,
        8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h2D, 8'h00,
        8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h0A,
        8'h07, 8'h05, 8'h02, 8'h03, 8'h08, 8'h00, 8'h00
    };

    localparam logic [7:0] RPT_ROM [0:RPT_LEN-1] = '{
        8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01,
        8'h05, 8'h07, 8'h19, 8'hE0, 8'h29, 8'hE7, 8'h15, 8'h00, 8'h25, 8'h01,
        8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02,
        8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h01,
        8'h95, 8'h06, 8'h75, 8'h08, 8'h15, 8'h00, 8'h25, 8'h65,
        8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h65, 8'h81, 8'h00,
        8'hC0
    };

    function automatic logic [7:0] desc_byte(op_t op, logic [5:0] idx,
                                             logic [15:0] vid, logic [15:0] pid);
        logic [7:0] b;
        b = 8'h00;
        unique case (op)
            OP_DESC_DEV:
            begin
                unique case (idx)
                    6'd0:    b = 8'h12;
                    6'd1:    b = 8'h01;
                    6'd3:    b = 8'h02;
                    6'd7:    b = 8'h40;
                    6'd8:    b = vid[7:0];
                    6'd9:    b = vid[15:8];
                    6'd10:   b = pid[7:0];
                    6'd11:   b = pid[15:8];
                    6'd17:   b = 8'h01;
                    default: b = 8'h00;
                endcase
            end
            OP_DESC_CFG: b = CFG_ROM[idx];
            OP_DESC_RPT: b = RPT_ROM[idx];
            default:     b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/usbhid_fifo.sv]
// Small first-in first-out queue of registers with a combinational head.
`timescale 1ns / 1ps

module usbhid_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign dout  = mem_reg[rd_ptr_reg];

    function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

endmodule

[rtl/usbhid_front.sv]
// Front end: accepts setup packets and bus resets and turns each into one command.
`timescale 1ns / 1ps

module usbhid_front (
    input  logic                 push,
    output logic                 full,
    input  logic                 req_type,
    input  logic [7:0]           request_type_bits,
    input  logic [7:0]           request_code,
    input  logic [15:0]          request_value,
    input  logic [15:0]          request_length,
    input  logic                 cmd_full,
    output logic                 cmd_push,
    output usbhid_pkg::cmd_t     cmd
);

    logic [7:0] dtype;
    logic [5:0] size;
    logic       is_desc;
    logic [5:0] clamped;

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;
    assign dtype    = request_value[15:8];

    always_comb
    begin
        cmd.op    = usbhid_pkg::OP_STALL;
        cmd.count = '0;
        cmd.addr  = request_value[6:0];
        is_desc   = 1'b0;
        size      = '0;
        clamped   = '0;
        priority if (req_type)
        begin
            cmd.op = usbhid_pkg::OP_BUS_RESET;
        end
        else if (request_code == usbhid_pkg::REQ_GET_DESC)
        begin
            priority if (request_type_bits == usbhid_pkg::BM_DEV_IN
                         && dtype == usbhid_pkg::DT_DEVICE)
            begin
                cmd.op  = usbhid_pkg::OP_DESC_DEV;
                size    = 6'(usbhid_pkg::DEV_LEN);
                is_desc = 1'b1;
            end
            else if (request_type_bits == usbhid_pkg::BM_DEV_IN
                     && dtype == usbhid_pkg::DT_CONFIG)
            begin
                cmd.op  = usbhid_pkg::OP_DESC_CFG;
                size    = 6'(usbhid_pkg::CFG_LEN);
                is_desc = 1'b1;
            end
            else if (request_type_bits == usbhid_pkg::BM_IF_IN
                     && dtype == usbhid_pkg::DT_REPORT)
            begin
                cmd.op  = usbhid_pkg::OP_DESC_RPT;
                size    = 6'(usbhid_pkg::RPT_LEN);
                is_desc = 1'b1;
            end
            else
            begin
                cmd.op = usbhid_pkg::OP_STALL;
            end
            clamped   = (request_length < {10'd0, size}) ? request_length[5:0] : size;
            cmd.count = clamped;
            if (is_desc && clamped == '0)
            begin
                cmd.op = usbhid_pkg::OP_EMPTY;
            end
        end
        else if (request_type_bits == usbhid_pkg::BM_STD_OUT
                 && request_code == usbhid_pkg::REQ_SET_ADDR)
        begin
            cmd.op = usbhid_pkg::OP_SET_ADDR;
        end
        else if (request_type_bits == usbhid_pkg::BM_CLASS_OUT
                 && request_code == usbhid_pkg::REQ_SET_IDLE)
        begin
            cmd.op = usbhid_pkg::OP_ACK;
        end
        else if (request_type_bits == usbhid_pkg::BM_STD_OUT
                 && request_code == usbhid_pkg::REQ_SET_CFG)
        begin
            cmd.op = usbhid_pkg::OP_SET_CFG;
        end
        else
        begin
            cmd.op = usbhid_pkg::OP_STALL;
        end
    end

endmodule

[rtl/usbhid_back.sv]
// Back end: executes commands, holds device state and streams descriptor bytes.
`timescale 1ns / 1ps

module usbhid_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          vendor_id,
    input  logic [15:0]          product_id,
    input  logic                 cmd_empty,
    input  usbhid_pkg::cmd_t     cmd,
    output logic                 cmd_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output usbhid_pkg::res_t     res
);

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t           state_reg, state_next;
    usbhid_pkg::op_t  op_reg, op_next;
    logic [5:0]       count_reg, count_next;
    logic [5:0]       index_reg, index_next;
    logic [6:0]       addr_reg, addr_next;
    logic             addr_en_reg, addr_en_next;
    logic             cfg_reg, cfg_next;
    logic             is_last;

    assign is_last = (index_reg == count_reg - 6'd1);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        count_next   = count_reg;
        index_next   = index_reg;
        addr_next    = addr_reg;
        addr_en_next = addr_en_reg;
        cfg_next     = cfg_reg;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res.kind     = usbhid_pkg::KIND_STALL;
        res.data     = 8'h00;
        res.last     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    res_push = 1'b1;
                    unique case (cmd.op)
                        usbhid_pkg::OP_DESC_DEV,
                        usbhid_pkg::OP_DESC_CFG,
                        usbhid_pkg::OP_DESC_RPT:
                        begin
                            res_push   = 1'b0;
                            op_next    = cmd.op;
                            count_next = cmd.count;
                            index_next = '0;
                            state_next = ST_STREAM;
                        end
                        usbhid_pkg::OP_EMPTY:    res.kind = usbhid_pkg::KIND_EMPTY;
                        usbhid_pkg::OP_SET_ADDR:
                        begin
                            addr_next    = cmd.addr;
                            addr_en_next = 1'b1;
                            res.kind     = usbhid_pkg::KIND_ACK;
                        end
                        usbhid_pkg::OP_SET_CFG:
                        begin
                            cfg_next = 1'b1;
                            res.kind = usbhid_pkg::KIND_ACK;
                        end
                        usbhid_pkg::OP_ACK:      res.kind = usbhid_pkg::KIND_ACK;
                        usbhid_pkg::OP_STALL:    res.kind = usbhid_pkg::KIND_STALL;
                        usbhid_pkg::OP_BUS_RESET:
                        begin
                            addr_next    = '0;
                            addr_en_next = 1'b0;
                            cfg_next     = 1'b0;
                            res.kind     = usbhid_pkg::KIND_RESET;
                        end
                        default:                 res.kind = usbhid_pkg::KIND_STALL;
                    endcase
                end
            end
            ST_STREAM:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    res.kind = usbhid_pkg::KIND_DATA;
                    res.data = usbhid_pkg::desc_byte(op_reg, index_reg, vendor_id, product_id);
                    res.last = is_last;
                    if (is_last)
                    begin
                        index_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        index_next = index_reg + 6'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        res.addr    = addr_next;
        res.addr_en = addr_en_next;
        res.cfg     = cfg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= usbhid_pkg::OP_STALL;
            count_reg   <= '0;
            index_reg   <= '0;
            addr_reg    <= '0;
            addr_en_reg <= 1'b0;
            cfg_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            count_reg   <= count_next;
            index_reg   <= index_next;
            addr_reg    <= addr_next;
            addr_en_reg <= addr_en_next;
            cfg_reg     <= cfg_next;
        end
    end

endmodule

[rtl/usb_hid_control_request_handler.sv]
// Top level of the USB HID control request handler: config registers, queues, front and back.
`timescale 1ns / 1ps

// Each setup packet or bus reset pushed in becomes one command in a short queue; the
// executor then produces its results into a result queue that is read by pop. A descriptor
// request of n bytes (n at most 45) is handled by first loading the command, which gives no
// result, and then sending one byte per cycle while the result queue has room; every other
// item gives its single result as it is taken from the command queue. Input is accepted as
// long as the command queue has room, also while results wait.
// vendor_id and product_id are read while the device descriptor streams out.
module usb_hid_control_request_handler #(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [7:0]  request_type_bits,
    input  logic [7:0]  request_code,
    input  logic [15:0] request_value,
    input  logic [15:0] request_length,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic [6:0]  device_address,
    output logic        address_enabled,
    output logic        configured
);

    logic [15:0]        vendor_id_reg;
    logic [15:0]        product_id_reg;
    usbhid_pkg::cmd_t   front_cmd;
    usbhid_pkg::cmd_t   head_cmd;
    logic               cmd_push;
    logic               cmd_full;
    logic               cmd_pop;
    logic               cmd_empty;
    usbhid_pkg::res_t   back_res;
    usbhid_pkg::res_t   head_res;
    logic               res_push;
    logic               res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_id_reg  <= usbhid_pkg::VENDOR_RESET;
            product_id_reg <= usbhid_pkg::PRODUCT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == usbhid_pkg::CFG_IDX_VENDOR)
            begin
                vendor_id_reg <= cfg_data;
            end
            if (cfg_index == usbhid_pkg::CFG_IDX_PRODUCT)
            begin
                product_id_reg <= cfg_data;
            end
        end
    end

    usbhid_front u_front (
        .push              (push),
        .full              (full),
        .req_type          (req_type),
        .request_type_bits (request_type_bits),
        .request_code      (request_code),
        .request_value     (request_value),
        .request_length    (request_length),
        .cmd_full          (cmd_full),
        .cmd_push          (cmd_push),
        .cmd               (front_cmd)
    );

    usbhid_fifo #(
        .WIDTH ($bits(usbhid_pkg::cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_push),
        .din   (front_cmd),
        .full  (cmd_full),
        .rd    (cmd_pop),
        .dout  (head_cmd),
        .empty (cmd_empty)
    );

    usbhid_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .vendor_id  (vendor_id_reg),
        .product_id (product_id_reg),
        .cmd_empty  (cmd_empty),
        .cmd        (head_cmd),
        .cmd_pop    (cmd_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (back_res)
    );

    usbhid_fifo #(
        .WIDTH ($bits(usbhid_pkg::res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .din   (back_res),
        .full  (res_full),
        .rd    (pop),
        .dout  (head_res),
        .empty (empty)
    );

    assign result_kind     = head_res.kind;
    assign data_byte       = head_res.data;
    assign last            = head_res.last;
    assign device_address  = head_res.addr;
    assign address_enabled = head_res.addr_en;
    assign configured      = head_res.cfg;

    // Only a data byte may leave the last flag low.
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != usbhid_pkg::KIND_DATA) |-> last)
        else $error("single result without last flag");

    // Non-data results carry a zero byte.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != usbhid_pkg::KIND_DATA) |-> (data_byte == 8'h00))
        else $error("non-data result with nonzero byte");

    // A bus reset result shows fully cleared device state.
    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == usbhid_pkg::KIND_RESET)
            |-> (device_address == '0 && !address_enabled && !configured))
        else $error("bus reset result with stale device state");

    // The executor never produces a result into a full result queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

endmodule

[sim/usb_hid_reply_checker.sv]
// Checker that predicts and compares every reply of the USB HID control request handler.
`timescale 1ns / 1ps

module usb_hid_reply_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic        req_type,
    input  logic [7:0]  request_type_bits,
    input  logic [7:0]  request_code,
    input  logic [15:0] request_value,
    input  logic [15:0] request_length,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  result_kind,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic [6:0]  device_address,
    input  logic        address_enabled,
    input  logic        configured,
    output int          mismatch_count,
    output int          pending_count,
    output int          checked_count,
    output int          byte_count
);

    localparam logic [7:0] CONFIG_BUNDLE [0:40] = '{
        8'h09, 8'h02, 8'h29, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h03, 8'h01, 8'h01, 8'h00,
        8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h2D, 8'h00,
        8'h07, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h0A,
        8'h07, 8'h05, 8'h02, 8'h03, 8'h08, 8'h00, 8'h00
    };

    localparam logic [7:0] REPORT_MAP [0:44] = '{
        8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01,
        8'h05, 8'h07, 8'h19, 8'hE0, 8'h29, 8'hE7, 8'h15, 8'h00, 8'h25, 8'h01,
        8'h75, 8'h01, 8'h95, 8'h08, 8'h81, 8'h02,
        8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h01,
        8'h95, 8'h06, 8'h75, 8'h08, 8'h15, 8'h00, 8'h25, 8'h65,
        8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h65, 8'h81, 8'h00,
        8'hC0
    };

    logic [15:0]        vendor_id;
    logic [15:0]        product_id;
    logic [6:0]         bus_address;
    logic               address_active;
    logic               config_done;
    usbhid_pkg::res_t   awaited_replies [$];
    usbhid_pkg::res_t   want;
    int                 fail_tally;
    int                 reply_tally;
    int                 data_tally;

    function automatic logic [7:0] descriptor_byte(usbhid_pkg::op_t source, int idx);
        logic [7:0] b;
        b = 8'h00;
        if (source == usbhid_pkg::OP_DESC_DEV)
        begin
            case (idx)
                0:       b = 8'h12;
                1:       b = 8'h01;
                3:       b = 8'h02;
                7:       b = 8'h40;
                8:       b = vendor_id[7:0];
                9:       b = vendor_id[15:8];
                10:      b = product_id[7:0];
                11:      b = product_id[15:8];
                17:      b = 8'h01;
                default: b = 8'h00;
            endcase
        end
        else if (source == usbhid_pkg::OP_DESC_CFG)
        begin
            b = CONFIG_BUNDLE[idx];
        end
        else
        begin
            b = REPORT_MAP[idx];
        end
        return b;
    endfunction

    function automatic void queue_reply(usbhid_pkg::kind_t kind, logic [7:0] b, logic fin);
        usbhid_pkg::res_t r;
        r.kind    = kind;
        r.data    = b;
        r.last    = fin;
        r.addr    = bus_address;
        r.addr_en = address_active;
        r.cfg     = config_done;
        awaited_replies.push_back(r);
    endfunction

    function automatic void predict_replies(logic bus_reset, logic [7:0] bm, logic [7:0] code,
                                            logic [15:0] val, logic [15:0] len);
        usbhid_pkg::op_t source;
        int              span;
        int              count;
        if (bus_reset)
        begin
            bus_address    = 7'd0;
            address_active = 1'b0;
            config_done    = 1'b0;
            queue_reply(usbhid_pkg::KIND_RESET, 8'h00, 1'b1);
        end
        else if (code == usbhid_pkg::REQ_GET_DESC)
        begin
            source = usbhid_pkg::OP_STALL;
            span   = 0;
            if (bm == usbhid_pkg::BM_DEV_IN && val[15:8] == usbhid_pkg::DT_DEVICE)
            begin
                source = usbhid_pkg::OP_DESC_DEV;
                span   = usbhid_pkg::DEV_LEN;
            end
            else if (bm == usbhid_pkg::BM_DEV_IN && val[15:8] == usbhid_pkg::DT_CONFIG)
            begin
                source = usbhid_pkg::OP_DESC_CFG;
                span   = usbhid_pkg::CFG_LEN;
            end
            else if (bm == usbhid_pkg::BM_IF_IN && val[15:8] == usbhid_pkg::DT_REPORT)
            begin
                source = usbhid_pkg::OP_DESC_RPT;
                span   = usbhid_pkg::RPT_LEN;
            end
            if (source == usbhid_pkg::OP_STALL)
            begin
                queue_reply(usbhid_pkg::KIND_STALL, 8'h00, 1'b1);
            end
            else
            begin
                count = (int'(len) < span) ? int'(len) : span;
                if (count == 0)
                begin
                    queue_reply(usbhid_pkg::KIND_EMPTY, 8'h00, 1'b1);
                end
                for (int i = 0; i < count; i++)
                begin
                    queue_reply(usbhid_pkg::KIND_DATA, descriptor_byte(source, i),
                                i == count - 1);
                end
            end
        end
        else if (bm == usbhid_pkg::BM_STD_OUT && code == usbhid_pkg::REQ_SET_ADDR)
        begin
            bus_address    = val[6:0];
            address_active = 1'b1;
            queue_reply(usbhid_pkg::KIND_ACK, 8'h00, 1'b1);
        end
        else if (bm == usbhid_pkg::BM_CLASS_OUT && code == usbhid_pkg::REQ_SET_IDLE)
        begin
            queue_reply(usbhid_pkg::KIND_ACK, 8'h00, 1'b1);
        end
        else if (bm == usbhid_pkg::BM_STD_OUT && code == usbhid_pkg::REQ_SET_CFG)
        begin
            config_done = 1'b1;
            queue_reply(usbhid_pkg::KIND_ACK, 8'h00, 1'b1);
        end
        else
        begin
            queue_reply(usbhid_pkg::KIND_STALL, 8'h00, 1'b1);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_id      = usbhid_pkg::VENDOR_RESET;
            product_id     = usbhid_pkg::PRODUCT_RESET;
            bus_address    = 7'd0;
            address_active = 1'b0;
            config_done    = 1'b0;
            awaited_replies.delete();
            fail_tally     = 0;
            reply_tally    = 0;
            data_tally     = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == usbhid_pkg::CFG_IDX_VENDOR)
                begin
                    vendor_id = cfg_data;
                end
                else
                begin
                    product_id = cfg_data;
                end
            end
            if (push && !full)
            begin
                predict_replies(req_type, request_type_bits, request_code,
                                request_value, request_length);
            end
            if (pop && !empty)
            begin
                reply_tally++;
                if (awaited_replies.size() == 0)
                begin
                    fail_tally++;
                    if (fail_tally <= 10)
                    begin
                        $display("reply %0d arrived with nothing outstanding: kind %0d data %02h",
                                 reply_tally, result_kind, data_byte);
                    end
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (want.kind == usbhid_pkg::KIND_DATA)
                    begin
                        data_tally++;
                    end
                    if (result_kind !== want.kind || data_byte !== want.data
                        || last !== want.last || device_address !== want.addr
                        || address_enabled !== want.addr_en || configured !== want.cfg)
                    begin
                        fail_tally++;
                        if (fail_tally <= 10)
                        begin
                            $display("reply %0d mismatch: expected kind %0d data %02h last %0b",
                                     reply_tally, want.kind, want.data, want.last,
                                     " addr %02h en %0b cfg %0b", want.addr, want.addr_en,
                                     want.cfg);
                            $display("    got kind %0d data %02h last %0b addr %02h en %0b cfg %0b",
                                     result_kind, data_byte, last, device_address,
                                     address_enabled, configured);
                        end
                    end
                end
            end
        end
        mismatch_count <= fail_tally;
        pending_count  <= awaited_replies.size();
        checked_count  <= reply_tally;
        byte_count     <= data_tally;
    end

endmodule

[sim/tb.sv]
// Testbench top of the USB HID control request handler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam logic      SETUP_PACKET    = 1'b0;
    localparam logic      BUS_RESET       = 1'b1;
    localparam logic [7:0] REQ_UNKNOWN    = 8'hFF;
    localparam logic [7:0] BM_ALL_ONES    = 8'hFF;
    localparam logic [7:0] DT_STRING      = 8'h03;
    localparam int        ITEMS_PER_PHASE = 48;
    localparam int        HOLD_AFTER      = 45;
    localparam int        HOLD_CYCLES     = 300;
    localparam int        SETTLE_CYCLES   = 8;
    localparam int        CYCLE_LIMIT     = 1000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        push;
    logic        full;
    logic        req_type;
    logic [7:0]  request_type_bits;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_length;
    logic        empty;
    logic        pop;
    logic [2:0]  result_kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [6:0]  device_address;
    logic        address_enabled;
    logic        configured;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int byte_count;
    int items_sent;
    int resets_sent;
    int input_stall_cycles;
    int cycle_count;
    bit hold_done;
    bit steady_sender;
    bit steady_receiver;

    usb_hid_control_request_handler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .req_type(req_type), .request_type_bits(request_type_bits),
        .request_code(request_code), .request_value(request_value),
        .request_length(request_length),
        .empty(empty), .pop(pop),
        .result_kind(result_kind), .data_byte(data_byte), .last(last),
        .device_address(device_address), .address_enabled(address_enabled),
        .configured(configured)
    );

    usb_hid_reply_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .req_type(req_type), .request_type_bits(request_type_bits),
        .request_code(request_code), .request_value(request_value),
        .request_length(request_length),
        .empty(empty), .pop(pop),
        .result_kind(result_kind), .data_byte(data_byte), .last(last),
        .device_address(device_address), .address_enabled(address_enabled),
        .configured(configured),
        .mismatch_count(mismatch_count), .pending_count(pending_count),
        .checked_count(checked_count), .byte_count(byte_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("usb_hid_control_request_handler regression: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_sender || r < 50)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_length(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            return 16'd0;
        end
        else if (r < 65)
        begin
            return 16'($urandom_range(1, span));
        end
        else if (r < 80)
        begin
            return 16'(span);
        end
        else if (r < 90)
        begin
            return 16'($urandom_range(span + 1, 255));
        end
        return 16'($urandom);
    endfunction

    task automatic offer_request(input logic rt, input logic [7:0] bm, input logic [7:0] code,
                                 input logic [15:0] val, input logic [15:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push              <= 1'b1;
        req_type          <= rt;
        request_type_bits <= bm;
        request_code      <= code;
        request_value     <= val;
        request_length    <= len;
        @(posedge clk);
        while (full)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        items_sent++;
        if (rt == BUS_RESET)
        begin
            resets_sent++;
        end
    endtask

    task automatic offer_random_request();
        int          pick;
        logic        rt;
        logic [7:0]  bm;
        logic [7:0]  code;
        logic [15:0] val;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        rt   = SETUP_PACKET;
        bm   = 8'($urandom);
        code = 8'($urandom);
        val  = 16'($urandom);
        len  = 16'($urandom);
        if (pick < 42)
        begin
            code = usbhid_pkg::REQ_GET_DESC;
            case ($urandom_range(0, 2))
                0:
                begin
                    bm  = usbhid_pkg::BM_DEV_IN;
                    val = {usbhid_pkg::DT_DEVICE, val[7:0]};
                    len = pick_length(usbhid_pkg::DEV_LEN);
                end
                1:
                begin
                    bm  = usbhid_pkg::BM_DEV_IN;
                    val = {usbhid_pkg::DT_CONFIG, val[7:0]};
                    len = pick_length(usbhid_pkg::CFG_LEN);
                end
                default:
                begin
                    bm  = usbhid_pkg::BM_IF_IN;
                    val = {usbhid_pkg::DT_REPORT, val[7:0]};
                    len = pick_length(usbhid_pkg::RPT_LEN);
                end
            endcase
        end
        else if (pick < 54)
        begin
            bm   = usbhid_pkg::BM_STD_OUT;
            code = usbhid_pkg::REQ_SET_ADDR;
        end
        else if (pick < 62)
        begin
            bm   = usbhid_pkg::BM_STD_OUT;
            code = usbhid_pkg::REQ_SET_CFG;
        end
        else if (pick < 70)
        begin
            bm   = usbhid_pkg::BM_CLASS_OUT;
            code = usbhid_pkg::REQ_SET_IDLE;
        end
        else if (pick < 76)
        begin
            rt = BUS_RESET;
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       bm = usbhid_pkg::BM_DEV_IN;
                1:       bm = usbhid_pkg::BM_IF_IN;
                2:       bm = usbhid_pkg::BM_STD_OUT;
                3:       bm = usbhid_pkg::BM_CLASS_OUT;
                default: bm = bm;
            endcase
            case ($urandom_range(0, 4))
                0:       code = usbhid_pkg::REQ_GET_DESC;
                1:       code = usbhid_pkg::REQ_SET_ADDR;
                2:       code = usbhid_pkg::REQ_SET_CFG;
                3:       code = usbhid_pkg::REQ_SET_IDLE;
                default: code = code;
            endcase
            case ($urandom_range(0, 3))
                0:       val = {usbhid_pkg::DT_DEVICE, val[7:0]};
                1:       val = {usbhid_pkg::DT_CONFIG, val[7:0]};
                2:       val = {usbhid_pkg::DT_REPORT, val[7:0]};
                default: val = val;
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                len = pick_length(usbhid_pkg::RPT_LEN);
            end
        end
        offer_request(rt, bm, code, val, len);
    endtask

    task automatic settle_idle();
        do
        begin
            @(posedge clk);
        end
        while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_ids(input logic [15:0] vid, input logic [15:0] pid);
        cfg_write <= 1'b1;
        cfg_index <= usbhid_pkg::CFG_IDX_VENDOR;
        cfg_data  <= vid;
        @(posedge clk);
        cfg_index <= usbhid_pkg::CFG_IDX_PRODUCT;
        cfg_data  <= pid;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int r;
        int round;
        pop   = 1'b0;
        round = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_sent >= HOLD_AFTER)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            round++;
            if (round % 64 == 0)
            begin
                steady_receiver = ($urandom_range(0, 2) == 0);
            end
            r = $urandom_range(0, 99);
            if (steady_receiver || r < 60)
            begin
                pop <= 1'b1;
            end
            else if (r < 95)
            begin
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b0;
                repeat ($urandom_range(5, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [15:0] vid;
        logic [15:0] pid;
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = usbhid_pkg::CFG_IDX_VENDOR;
        cfg_data          = 16'h0000;
        push              = 1'b0;
        req_type          = SETUP_PACKET;
        request_type_bits = 8'h00;
        request_code      = 8'h00;
        request_value     = 16'h0000;
        request_length    = 16'h0000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_request(BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_DEVICE, 8'h00}, 16'(usbhid_pkg::DEV_LEN));
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_DEVICE, 8'h00}, 16'd0);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_DEVICE, 8'h00}, 16'd1);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_DEVICE, 8'h00}, 16'hFFFF);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_CONFIG, 8'h00}, 16'hFFFF);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_CONFIG, 8'h00}, 16'd9);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_IF_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_REPORT, 8'h00}, 16'(usbhid_pkg::RPT_LEN));
        offer_request(SETUP_PACKET, usbhid_pkg::BM_IF_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_REPORT, 8'h00}, 16'hFFFF);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_IF_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_REPORT, 8'h00}, 16'd0);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_REPORT, 8'h00}, 16'd45);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_IF_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_DEVICE, 8'h00}, 16'd18);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {DT_STRING, 8'h00}, 16'd255);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_DEVICE, 8'hFF}, 16'd20);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_STD_OUT, usbhid_pkg::REQ_SET_ADDR,
                      16'hFFFF, 16'h0000);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_SET_ADDR,
                      16'h0012, 16'h0000);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_CLASS_OUT, usbhid_pkg::REQ_SET_IDLE,
                      16'hFFFF, 16'hFFFF);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_STD_OUT, usbhid_pkg::REQ_SET_IDLE,
                      16'h0000, 16'h0000);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_STD_OUT, usbhid_pkg::REQ_SET_CFG,
                      16'h0000, 16'h0000);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_CLASS_OUT, usbhid_pkg::REQ_SET_CFG,
                      16'h0001, 16'h0000);
        offer_request(SETUP_PACKET, BM_ALL_ONES, REQ_UNKNOWN, 16'hFFFF, 16'hFFFF);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_STD_OUT, usbhid_pkg::REQ_SET_ADDR,
                      16'h0000, 16'h0000);
        offer_request(BUS_RESET, BM_ALL_ONES, REQ_UNKNOWN, 16'hFFFF, 16'hFFFF);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_STD_OUT, usbhid_pkg::REQ_SET_ADDR,
                      16'h0055, 16'h0000);
        offer_request(SETUP_PACKET, usbhid_pkg::BM_DEV_IN, usbhid_pkg::REQ_GET_DESC,
                      {usbhid_pkg::DT_DEVICE, 8'h00}, 16'd17);
        push <= 1'b0;
        settle_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    vid = 16'h0000;
                    pid = 16'hFFFF;
                end
                1:
                begin
                    vid = 16'hFFFF;
                    pid = 16'h0000;
                end
                2:
                begin
                    vid = 16'($urandom);
                    pid = 16'($urandom);
                end
                default:
                begin
                    vid = usbhid_pkg::VENDOR_RESET;
                    pid = usbhid_pkg::PRODUCT_RESET;
                end
            endcase
            load_ids(vid, pid);
            steady_sender = (phase == 2);
            repeat (ITEMS_PER_PHASE) offer_random_request();
            push <= 1'b0;
            settle_idle();
        end

        $display("Covered %0d requests (%0d bus resets) under five vendor/product settings;",
                 items_sent, resets_sent);
        $display("%0d replies checked, %0d of them descriptor bytes; input held off %0d cycles.",
                 checked_count, byte_count, input_stall_cycles);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("usb_hid_control_request_handler regression: pass");
        end
        else
        begin
            $display("usb_hid_control_request_handler regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/usbhid_pkg.sv
rtl/usbhid_fifo.sv
rtl/usbhid_front.sv
rtl/usbhid_back.sv
rtl/usb_hid_control_request_handler.sv
sim/usb_hid_reply_checker.sv
sim/tb.sv
